>>> rtl/iva_pkg.sv
`timescale 1ns / 1ps
package iva_pkg;

  localparam logic [1:0] FUNC_LOAD   = 2'd0;
  localparam logic [1:0] FUNC_SITE   = 2'd1;
  localparam logic [1:0] FUNC_FINISH = 2'd2;

  localparam int unsigned SUM_W  = 56;
  localparam int unsigned CNT_W  = 24;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned LANES  = 4;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
  localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ACT_RD,
    ST_ACT_CHK,
    ST_UPD_RD,
    ST_UPD_CHK,
    ST_UPD_SUM,
    ST_FIN_RD,
    ST_FIN_SUM,
    ST_FIN_DIV,
    ST_FIN_OUT
  } state_e;

endpackage

>>> rtl/iva_div.sv
`timescale 1ns / 1ps
// radix-2 restoring divider, signed 56-bit by unsigned 24-bit, result clamped to 32 bits
module iva_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic signed [iva_pkg::SUM_W-1:0]  dividend_i,
  input  logic        [iva_pkg::CNT_W-1:0]  divisor_i,
  output logic                              busy_o,
  output logic                              done_o,
  output logic signed [iva_pkg::VAL_W-1:0]  quot_o
);

  localparam int unsigned SW = iva_pkg::SUM_W;
  localparam int unsigned CW = iva_pkg::CNT_W;
  localparam logic [5:0] LAST_STEP = 6'(SW - 1);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [5:0]    step_q, step_d;
  logic [CW-1:0] rem_q, rem_d;
  logic [CW-1:0] div_q, div_d;
  logic [SW-1:0] quo_q, quo_d;
  logic          neg_q, neg_d;
  logic [CW:0]   rem_sh;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    rem_d  = rem_q;
    div_d  = div_q;
    quo_d  = quo_q;
    neg_d  = neg_q;
    rem_sh = {rem_q, quo_q[SW-1]};
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      rem_d  = '0;
      div_d  = divisor_i;
      neg_d  = dividend_i[SW-1];
      quo_d  = dividend_i[SW-1] ? SW'(-dividend_i) : SW'(dividend_i);
    end else if (busy_q) begin
      if (rem_sh >= {1'b0, div_q}) begin
        rem_d = CW'(rem_sh - {1'b0, div_q});
        quo_d = {quo_q[SW-2:0], 1'b1};
      end else begin
        rem_d = rem_sh[CW-1:0];
        quo_d = {quo_q[SW-2:0], 1'b0};
      end
      step_d = step_q + 6'd1;
      if (step_q == LAST_STEP) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    div_q <= div_d;
    quo_q <= quo_d;
    neg_q <= neg_d;
  end

  always_comb begin
    if (!neg_q) begin
      quot_o = (quo_q > SW'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : $signed(quo_q[31:0]);
    end else begin
      quot_o = (quo_q > SW'(32'h8000_0000)) ? $signed(32'h8000_0000)
                                             : $signed(-quo_q[31:0]);
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;

endmodule

>>> rtl/interval_window_average.sv
`timescale 1ns / 1ps
// Sweep-line interval averager. Region loads (func 0) are written straight into the region
// tables. A site (func 1) first walks the pending queue, activating regions, then visits
// every region slot: an inactive slot is passed over, an active slot is checked and either
// retires or stays active and has each of its SAMPLES sums updated, and the sweep closes
// after the last slot. A single shared 56-bit saturating adder updates one sample sum per
// cycle out of a sum memory with one read and one write port. A finish (func 2) emits one
// result per loaded region; each sample sum is divided by the region's site count (skipped
// when the region saw no sites) in the one radix-2 divider producing one quotient bit per
// cycle, and each result is held while out_stall_i is high. State clears at the end of the
// finish run without a clearing pass. in_stall_o is high while any item is at work.
module interval_window_average #(
  parameter int unsigned REGIONS = 64,
  parameter int unsigned SAMPLES = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          func_i,
  input  logic [31:0]         region_start_i,
  input  logic [31:0]         region_end_i,
  input  logic [31:0]         position_i,
  input  logic signed [31:0]  sample_0_i,
  input  logic signed [31:0]  sample_1_i,
  input  logic signed [31:0]  sample_2_i,
  input  logic signed [31:0]  sample_3_i,
  input  logic [3:0]          sample_present_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [5:0]          region_index_o,
  output logic signed [31:0]  average_0_o,
  output logic signed [31:0]  average_1_o,
  output logic signed [31:0]  average_2_o,
  output logic signed [31:0]  average_3_o,
  output logic [23:0]         site_count_o,
  output logic                no_data_o,
  output logic                last_region_o
);

  localparam int unsigned RIW = (REGIONS > 1) ? $clog2(REGIONS) : 1;
  localparam int unsigned CW  = $clog2(REGIONS + 1);
  localparam int unsigned SIW = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
  localparam int unsigned SAW = RIW + SIW;
  localparam int unsigned SUMW = iva_pkg::SUM_W;
  localparam int unsigned CNTW = iva_pkg::CNT_W;
  localparam logic [CW-1:0]  REG_CNT  = CW'(REGIONS);
  localparam logic [SIW-1:0] LAST_SMP = SIW'(SAMPLES - 1);

  iva_pkg::state_e state_q, state_d;

  logic               mode_q;
  logic [CW-1:0]      ld_q, ld_d;
  logic [CW-1:0]      np_q, np_d;
  logic [CW-1:0]      r_q, r_d;
  logic [SIW-1:0]     s_q, s_d;
  logic [REGIONS-1:0] act_q, act_d;
  logic [REGIONS-1:0] vld_q, vld_d;
  logic [31:0]        pos_q, pos_d;
  logic [3:0]         pres_q, pres_d;
  logic [31:0]        samp_q [4];
  logic [31:0]        samp_d [4];
  logic [CNTW-1:0]    cnt_q, cnt_d;
  logic [31:0]        avg_q [4];
  logic [31:0]        avg_d [4];

  logic [31:0]     start_mem [REGIONS];
  logic [31:0]     end_mem [REGIONS];
  logic [CNTW-1:0] cnt_mem [REGIONS];
  logic [SUMW-1:0] sum_mem [2**SAW];

  logic            tab_we;
  logic            st_re;
  logic [RIW-1:0]  st_ra;
  logic [31:0]     st_rd, en_rd;
  logic            cnt_re, cnt_we;
  logic [RIW-1:0]  cnt_a;
  logic [CNTW-1:0] cnt_wd, cnt_rd;
  logic            sum_re, sum_we;
  logic [SAW-1:0]  sum_ra, sum_wa;
  logic [SUMW-1:0] sum_wd, sum_rd;

  logic                   div_start, div_busy, div_done;
  logic signed [SUMW-1:0] div_num;
  logic signed [31:0]     div_quot;

  logic [RIW-1:0]  ri, npi;
  logic            row_vld;
  logic [SUMW-1:0] sum_cur;
  logic [SUMW:0]   sum_ext;
  logic [CNTW-1:0] cnt_eff;
  logic            cfg_wr;
  logic            fin_adv;

  // configuration
  assign cfg_wr = psel & penable & pwrite & pready;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {31'd0, mode_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (cfg_wr && paddr[2] == 1'b0) begin
      mode_q <= pwdata[0];
    end
  end

  // memories
  always_ff @(posedge clk_i) begin
    if (tab_we) begin
      start_mem[ld_q[RIW-1:0]] <= region_start_i;
      end_mem[ld_q[RIW-1:0]]   <= region_end_i;
    end
    if (st_re) begin
      st_rd <= start_mem[st_ra];
      en_rd <= end_mem[st_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      cnt_mem[cnt_a] <= cnt_wd;
    end
    if (cnt_re) begin
      cnt_rd <= cnt_mem[cnt_a];
    end
  end

  always_ff @(posedge clk_i) begin
    if (sum_we) begin
      sum_mem[sum_wa] <= sum_wd;
    end
    if (sum_re) begin
      sum_rd <= sum_mem[sum_ra];
    end
  end

  assign ri      = r_q[RIW-1:0];
  assign npi     = np_q[RIW-1:0];
  assign row_vld = vld_q[ri];
  assign sum_cur = row_vld ? sum_rd : '0;
  assign cnt_eff = row_vld ? cnt_rd : '0;
  assign sum_ext = {sum_cur[SUMW-1], sum_cur}
                 + {{(SUMW-31){samp_q[2'(s_q)][31]}}, samp_q[2'(s_q)]};
  assign div_num = $signed(sum_cur);

  always_comb begin
    state_d   = state_q;
    ld_d      = ld_q;
    np_d      = np_q;
    r_d       = r_q;
    s_d       = s_q;
    act_d     = act_q;
    vld_d     = vld_q;
    pos_d     = pos_q;
    pres_d    = pres_q;
    samp_d    = samp_q;
    cnt_d     = cnt_q;
    avg_d     = avg_q;
    tab_we    = 1'b0;
    st_re     = 1'b0;
    st_ra     = ri;
    cnt_re    = 1'b0;
    cnt_we    = 1'b0;
    cnt_a     = ri;
    cnt_wd    = cnt_q;
    sum_re    = 1'b0;
    sum_ra    = {ri, s_q};
    sum_we    = 1'b0;
    sum_wa    = {ri, s_q};
    sum_wd    = sum_cur;
    div_start = 1'b0;
    fin_adv   = 1'b0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;

    unique case (state_q)
      iva_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          unique case (func_i)
            iva_pkg::FUNC_LOAD: begin
              if (ld_q < REG_CNT) begin
                tab_we = 1'b1;
                ld_d   = ld_q + CW'(1);
              end
            end
            iva_pkg::FUNC_SITE: begin
              pos_d     = position_i;
              pres_d    = sample_present_i;
              samp_d[0] = sample_0_i;
              samp_d[1] = sample_1_i;
              samp_d[2] = sample_2_i;
              samp_d[3] = sample_3_i;
              state_d   = iva_pkg::ST_ACT_RD;
            end
            iva_pkg::FUNC_FINISH: begin
              r_d = '0;
              if (ld_q == '0) begin
                act_d = '0;
                vld_d = '0;
                np_d  = '0;
              end else begin
                state_d = iva_pkg::ST_FIN_RD;
              end
            end
            default: ;
          endcase
        end
      end

      iva_pkg::ST_ACT_RD: begin
        if (np_q < ld_q) begin
          st_re   = 1'b1;
          st_ra   = npi;
          state_d = iva_pkg::ST_ACT_CHK;
        end else begin
          r_d     = '0;
          state_d = iva_pkg::ST_UPD_RD;
        end
      end

      iva_pkg::ST_ACT_CHK: begin
        if (mode_q ? (st_rd <= pos_q) : (st_rd < pos_q)) begin
          act_d[npi] = 1'b1;
          np_d       = np_q + CW'(1);
          state_d    = iva_pkg::ST_ACT_RD;
        end else begin
          r_d     = '0;
          state_d = iva_pkg::ST_UPD_RD;
        end
      end

      iva_pkg::ST_UPD_RD: begin
        if (r_q == REG_CNT) begin
          state_d = iva_pkg::ST_IDLE;
        end else if (act_q[ri]) begin
          st_re   = 1'b1;
          cnt_re  = 1'b1;
          state_d = iva_pkg::ST_UPD_CHK;
        end else begin
          r_d = r_q + CW'(1);
        end
      end

      iva_pkg::ST_UPD_CHK: begin
        cnt_d = cnt_eff;
        if (!((mode_q ? (st_rd <= pos_q) : (st_rd < pos_q)) && pos_q <= en_rd)) begin
          act_d[ri] = 1'b0;
          r_d       = r_q + CW'(1);
          state_d   = iva_pkg::ST_UPD_RD;
        end else begin
          s_d     = '0;
          sum_re  = 1'b1;
          sum_ra  = {ri, SIW'(0)};
          state_d = iva_pkg::ST_UPD_SUM;
        end
      end

      iva_pkg::ST_UPD_SUM: begin
        sum_we = 1'b1;
        if (pres_q[2'(s_q)]) begin
          if (sum_ext[SUMW] != sum_ext[SUMW-1]) begin
            sum_wd = sum_ext[SUMW] ? iva_pkg::SUM_MIN : iva_pkg::SUM_MAX;
          end else begin
            sum_wd = sum_ext[SUMW-1:0];
          end
        end
        if (s_q == LAST_SMP) begin
          cnt_we    = 1'b1;
          cnt_wd    = (cnt_q == iva_pkg::CNT_MAX) ? cnt_q : cnt_q + CNTW'(1);
          vld_d[ri] = 1'b1;
          r_d       = r_q + CW'(1);
          state_d   = iva_pkg::ST_UPD_RD;
        end else begin
          s_d    = s_q + SIW'(1);
          sum_re = 1'b1;
          sum_ra = {ri, s_q + SIW'(1)};
        end
      end

      iva_pkg::ST_FIN_RD: begin
        for (int i = 0; i < 4; i++) begin
          avg_d[i] = '0;
        end
        s_d     = '0;
        cnt_re  = 1'b1;
        sum_re  = 1'b1;
        sum_ra  = {ri, SIW'(0)};
        state_d = iva_pkg::ST_FIN_SUM;
      end

      iva_pkg::ST_FIN_SUM, iva_pkg::ST_FIN_DIV: begin
        cnt_d = cnt_eff;
        if (state_q == iva_pkg::ST_FIN_SUM) begin
          if (cnt_eff == '0) begin
            fin_adv = 1'b1;
          end else begin
            div_start = 1'b1;
            state_d   = iva_pkg::ST_FIN_DIV;
          end
        end else if (div_done) begin
          avg_d[2'(s_q)] = div_quot;
          fin_adv        = 1'b1;
        end
        if (fin_adv) begin
          if (s_q == LAST_SMP) begin
            state_d = iva_pkg::ST_FIN_OUT;
          end else begin
            s_d     = s_q + SIW'(1);
            sum_re  = 1'b1;
            sum_ra  = {ri, s_q + SIW'(1)};
            state_d = iva_pkg::ST_FIN_SUM;
          end
        end
      end

      iva_pkg::ST_FIN_OUT: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          if (r_q + CW'(1) == ld_q) begin
            act_d   = '0;
            vld_d   = '0;
            ld_d    = '0;
            np_d    = '0;
            state_d = iva_pkg::ST_IDLE;
          end else begin
            r_d     = r_q + CW'(1);
            state_d = iva_pkg::ST_FIN_RD;
          end
        end
      end

      default: state_d = iva_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= iva_pkg::ST_IDLE;
      ld_q    <= '0;
      np_q    <= '0;
      r_q     <= '0;
      s_q     <= '0;
      act_q   <= '0;
      vld_q   <= '0;
    end else begin
      state_q <= state_d;
      ld_q    <= ld_d;
      np_q    <= np_d;
      r_q     <= r_d;
      s_q     <= s_d;
      act_q   <= act_d;
      vld_q   <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q  <= pos_d;
    pres_q <= pres_d;
    samp_q <= samp_d;
    cnt_q  <= cnt_d;
    avg_q  <= avg_d;
  end

  iva_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_num),
    .divisor_i  (cnt_eff),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  assign region_index_o = 6'(r_q);
  assign average_0_o    = avg_q[0];
  assign average_1_o    = avg_q[1];
  assign average_2_o    = avg_q[2];
  assign average_3_o    = avg_q[3];
  assign site_count_o   = cnt_q;
  assign no_data_o      = (cnt_q == '0);
  assign last_region_o  = (r_q + CW'(1) == ld_q);

  a_out_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("result offered while input side open");

  a_pending : assert property (@(posedge clk_i) disable iff (!rst_ni)
    np_q <= ld_q)
    else $error("pending pointer beyond loaded regions");

  a_div_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy)
    else $error("divider restarted while busy");

  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(r_q)))
    else $error("stalled transfer dropped");

endmodule
